// File: design/knn_pkg.sv
package knn_pkg;

	// fixed field widths
	localparam int COORD_W = 24;
	localparam int DIST_W  = 50;
	localparam int CAND_W  = 16;
	localparam int RANK_W  = 5;
	localparam int OP_W    = 2;
	localparam int CFG_W   = 6;

	// defaults for the top level parameters
	localparam int MAX_NEIGHBORS_DEF = 32;
	localparam int INDEX_BITS_DEF    = 16;

	// behavior constants
	localparam int READOUT_MAX   = 32;
	localparam int ENOUGH_COUNT  = 3;
	localparam int LIMIT_RESET   = 16;
	localparam int QUEUE_DEPTH   = 4;

	// op codes
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
	localparam logic [OP_W-1:0] OP_OFFER  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [CAND_W-1:0]         cand_index;
	} in_word_t;

	typedef struct packed {
		logic [CAND_W-1:0] nb_index;
		logic [DIST_W-1:0] nb_dist_sq;
		logic [RANK_W-1:0] rank;
		logic              entry_valid;
		logic              enough_found;
		logic              last;
	} out_word_t;

	// classified command from front to back
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DIST_W-1:0] dist_sq;
		logic [CAND_W-1:0] idx;
	} cmd_t;

endpackage

// File: design/knn_stream_if.sv
interface knn_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/knn_front.sv
module knn_front #(
	parameter int INDEX_BITS = knn_pkg::INDEX_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	knn_stream_if.sink          req,
	output logic                push_valid,
	input  logic                push_ready,
	output knn_pkg::cmd_t       push_cmd
);

	localparam int CW = knn_pkg::COORD_W;
	localparam int SQ_W = 2 * CW;

	function automatic logic [CW-1:0] abs_diff(
		input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b
	);
		logic signed [CW:0] d;
		logic [CW:0] m;
		begin
			d = {a[CW-1], a} - {b[CW-1], b};
			m = d[CW] ? -d : d;
			abs_diff = m[CW-1:0];
		end
	endfunction

	// query point, updated as a query word is accepted
	logic signed [CW-1:0] qx_q, qy_q, qz_q;

	logic                     v_s1, v_s2, v_s3;
	logic [knn_pkg::OP_W-1:0] op_s1, op_s2, op_s3;
	logic [CW-1:0]            adx_s1, ady_s1, adz_s1;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [knn_pkg::DIST_W-1:0] dist_s3;
	logic [knn_pkg::CAND_W-1:0] idx_s1, idx_s2, idx_s3;

	logic en, accept;
	logic [INDEX_BITS+knn_pkg::CAND_W-1:0] idx_wide;
	logic [INDEX_BITS-1:0]                 idx_keep;
	logic [knn_pkg::CAND_W+INDEX_BITS-1:0] idx_back;

	// stall the whole pipe only when the tail word cannot enter the queue
	assign en = !v_s3 || push_ready;
	assign req.ready = en;
	assign accept = req.valid && en;

	// keep only the low INDEX_BITS bits of the point index
	assign idx_wide = {{INDEX_BITS{1'b0}}, req.data.cand_index};
	assign idx_keep = idx_wide[INDEX_BITS-1:0];
	assign idx_back = {{knn_pkg::CAND_W{1'b0}}, idx_keep};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
		end else if (accept && req.data.op == knn_pkg::OP_QUERY) begin
			qx_q <= req.data.coord_x;
			qy_q <= req.data.coord_y;
			qz_q <= req.data.coord_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && req.data.op != knn_pkg::OP_UNUSED;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= req.data.op;
			adx_s1 <= abs_diff(req.data.coord_x, qx_q);
			ady_s1 <= abs_diff(req.data.coord_y, qy_q);
			adz_s1 <= abs_diff(req.data.coord_z, qz_q);
			idx_s1 <= idx_back[knn_pkg::CAND_W-1:0];

			op_s2  <= op_s1;
			sqx_s2 <= adx_s1 * adx_s1;
			sqy_s2 <= ady_s1 * ady_s1;
			sqz_s2 <= adz_s1 * adz_s1;
			idx_s2 <= idx_s1;

			op_s3   <= op_s2;
			dist_s3 <= knn_pkg::DIST_W'(sqx_s2) + knn_pkg::DIST_W'(sqy_s2)
				+ knn_pkg::DIST_W'(sqz_s2);
			idx_s3  <= idx_s2;
		end
	end

	assign push_valid       = v_s3;
	assign push_cmd.op      = op_s3;
	assign push_cmd.dist_sq = dist_s3;
	assign push_cmd.idx     = idx_s3;

endmodule

// File: design/knn_queue.sv
module knn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  knn_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output knn_pkg::cmd_t pop_cmd
);

	localparam int DEPTH = knn_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	knn_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: design/knn_back.sv
module knn_back #(
	parameter int MAX_NEIGHBORS = knn_pkg::MAX_NEIGHBORS_DEF,
	parameter int INDEX_BITS    = knn_pkg::INDEX_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [knn_pkg::CFG_W-1:0] cfg_data,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  knn_pkg::cmd_t             pop_cmd,
	knn_stream_if.source              rsp
);

	localparam int AW = $clog2(MAX_NEIGHBORS);
	localparam int FW = $clog2(MAX_NEIGHBORS + 1);
	localparam int RD_MAX = (MAX_NEIGHBORS < knn_pkg::READOUT_MAX) ?
		MAX_NEIGHBORS : knn_pkg::READOUT_MAX;
	localparam int DW = knn_pkg::DIST_W;
	localparam int NW = knn_pkg::CAND_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic [knn_pkg::CFG_W-1:0] limit_q;
	logic [FW-1:0] found_q;

	// sorted list, one row per rank
	logic [DW-1:0]         dist_q [MAX_NEIGHBORS];
	logic [INDEX_BITS-1:0] idx_q  [MAX_NEIGHBORS];

	logic [FW-1:0] rd_r_q, rd_n_q, rd_next, rd_n;
	logic rd_empty_q, rd_enough_q;

	knn_pkg::out_word_t out_q;
	logic out_v_q;

	logic fire, do_ins, load, is_last;
	logic [7:0] lim_ext;
	logic [FW-1:0] k, fc_eff;
	logic [MAX_NEIGHBORS-1:0] gt;
	logic [INDEX_BITS-1:0] cand_idx;
	logic [NW+INDEX_BITS-1:0] idx_cut;
	logic [INDEX_BITS+NW-1:0] out_idx_wide;

	assign pop_ready = state_q == ST_IDLE;
	assign fire      = pop_valid && pop_ready;

	// k = min(limit, depth); a list left longer by a lowered limit is cut first
	assign lim_ext = {2'b00, limit_q};
	assign k       = (lim_ext < 8'(MAX_NEIGHBORS)) ? FW'(lim_ext) : FW'(MAX_NEIGHBORS);
	assign fc_eff  = (found_q > k) ? k : found_q;
	assign do_ins  = fire && pop_cmd.op == knn_pkg::OP_OFFER && k != '0;

	assign idx_cut  = {{INDEX_BITS{1'b0}}, pop_cmd.idx};
	assign cand_idx = idx_cut[INDEX_BITS-1:0];

	// each row decides on its own: keep, take the new entry, or take the row above
	for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_row
		always_comb begin
			if (FW'(i) < fc_eff) begin
				gt[i] = dist_q[i] > pop_cmd.dist_sq;
			end else begin
				gt[i] = (FW'(i) == fc_eff) && (fc_eff < k);
			end
		end

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_ins && gt[0]) begin
					dist_q[0] <= pop_cmd.dist_sq;
					idx_q[0]  <= cand_idx;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (do_ins && FW'(i) < k) begin
					if (gt[i-1]) begin
						dist_q[i] <= dist_q[i-1];
						idx_q[i]  <= idx_q[i-1];
					end else if (gt[i]) begin
						dist_q[i] <= pop_cmd.dist_sq;
						idx_q[i]  <= cand_idx;
					end
				end
			end
		end
	end

	assign rd_n    = (found_q < FW'(RD_MAX)) ? found_q : FW'(RD_MAX);
	assign rd_next = rd_r_q + 1'b1;
	assign is_last = rd_next == rd_n_q;
	assign load    = state_q == ST_READ && (!out_v_q || rsp.ready);
	assign out_idx_wide = {{NW{1'b0}}, idx_q[rd_r_q[AW-1:0]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= knn_pkg::CFG_W'(knn_pkg::LIMIT_RESET);
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= '0;
			rd_r_q  <= '0;
			rd_n_q  <= '0;
			rd_empty_q  <= 1'b0;
			rd_enough_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						unique case (pop_cmd.op)
							knn_pkg::OP_QUERY: begin
								found_q <= '0;
							end
							knn_pkg::OP_OFFER: begin
								if (k != '0) begin
									found_q <= (fc_eff < k) ? fc_eff + 1'b1 : fc_eff;
								end
							end
							knn_pkg::OP_READ: begin
								state_q     <= ST_READ;
								rd_r_q      <= '0;
								rd_empty_q  <= rd_n == '0;
								rd_n_q      <= (rd_n == '0) ? FW'(1) : rd_n;
								rd_enough_q <= found_q >= FW'(knn_pkg::ENOUGH_COUNT);
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (load) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_r_q <= rd_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.rank <= knn_pkg::RANK_W'(rd_r_q);
			out_q.last <= is_last;
			if (rd_empty_q) begin
				out_q.nb_index     <= '0;
				out_q.nb_dist_sq   <= '0;
				out_q.entry_valid  <= 1'b0;
				out_q.enough_found <= 1'b0;
			end else begin
				out_q.nb_index     <= out_idx_wide[NW-1:0];
				out_q.nb_dist_sq   <= dist_q[rd_r_q[AW-1:0]];
				out_q.entry_valid  <= 1'b1;
				out_q.enough_found <= rd_enough_q;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

endmodule

// File: design/knn_topk_insertion_select.sv
// k nearest neighbor selector, insertion top-k.
// req (sink): one word per operation. op QUERY loads the query point and empties
//   the list, op OFFER offers a candidate point with its index, op READ reads the
//   list out. op code 3 is dropped at the input.
// rsp (source): READ only. One word per list entry in rank order, nearest first,
//   last set on the final word; an empty list gives one word with entry_valid 0.
// cfg_we/cfg_data: neighbor limit k (reset 16), clamped to MAX_NEIGHBORS.
// Throughput: one req word per cycle while req.ready is high. The front distance
//   pipe takes a word each cycle unless stalled; the back retires a QUERY or
//   OFFER with a single compare and shift across all list rows. A READ holds the
//   back, one rsp word per cycle while rsp.ready is high, until its last word is
//   loaded; only then does the back take the next word. An accepted word passes
//   the 3 pipe stages and the queue to reach the back; rsp words are registered.
// Reset: query point and list count cleared, limit back to 16; list rows are
//   not cleared, only rows below the count are ever read.
// Stall: rsp holds its word while ready is low; the back stops, the queue fills,
//   and req.ready drops once the queue is full and the last pipe stage holds a
//   word. The pipe stalls as a whole, so bubbles in it are kept.
module knn_topk_insertion_select #(
	parameter int MAX_NEIGHBORS = knn_pkg::MAX_NEIGHBORS_DEF,
	parameter int INDEX_BITS    = knn_pkg::INDEX_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	knn_stream_if.sink                req,
	knn_stream_if.source              rsp,
	input  logic                      cfg_we,
	input  logic [knn_pkg::CFG_W-1:0] cfg_data
);

	// front -> queue
	logic          push_valid, push_ready;
	knn_pkg::cmd_t push_cmd;
	// queue -> back
	logic          pop_valid, pop_ready;
	knn_pkg::cmd_t pop_cmd;

	// distance pipe: |dx|,|dy|,|dz| -> squares -> sum
	knn_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// short queue so the front keeps streaming while the back reads out
	knn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// sorted list, limit register and readout sequencer
	knn_back #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS),
		.INDEX_BITS    (INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.rsp       (rsp)
	);

endmodule

// File: test/knn_topk_insertion_select_tb.sv
module knn_topk_insertion_select_tb;

	import knn_pkg::*;

	localparam int MAX_NB         = MAX_NEIGHBORS_DEF;
	localparam int IDLE_PCT       = 31;   // chance per cycle that a side idles
	localparam int SETTLE         = 12;   // back-end latency plus margin, used when idle
	localparam int HOLD_CYCLES    = 200;  // long receiver stall to back up the input
	localparam int WATCHDOG_LIMIT = 3000; // cycles with no word moving on either side
	localparam int ITEM_TARGET    = 160;

	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	// squared distance of all-min from the origin: 3 * 2^46
	localparam logic [DIST_W-1:0] DIST_MIN_ORIGIN = 50'h0_C000_0000_0000;
	// squared distance of all-max from all-min: 3 * (2^24 - 1)^2
	localparam logic [DIST_W-1:0] DIST_FULL_SPAN  = 50'h2_FFFF_FA00_0003;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_data;

	knn_stream_if #(.word_t(in_word_t))  req_if ();
	knn_stream_if #(.word_t(out_word_t)) rsp_if ();

	knn_topk_insertion_select #(
		.MAX_NEIGHBORS(MAX_NB),
		.INDEX_BITS(INDEX_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: query point, sorted neighbor list, count, limit k
	// ------------------------------------------------------------------
	logic signed [COORD_W-1:0] qry_x, qry_y, qry_z;
	logic [DIST_W-1:0]         nb_dist [MAX_NB];
	logic [CAND_W-1:0]         nb_idx  [MAX_NB];
	int unsigned               found_n;
	logic [CFG_W-1:0]          k_limit;

	out_word_t readout_q[$];   // expected rsp words, oldest first

	int  mismatch_count = 0;
	int  item_count = 0;       // accepted words other than the unused op
	int  idle_pct = IDLE_PCT;
	bit  hold_req = 1'b0;      // stimulus asks the receiver for a long stall
	int  hold_left = 0;
	int  quiet_cycles = 0;

	// Directed table: a row either carries a typed-in single-word readout or
	// leaves the expectation to the predictor.
	typedef struct packed {
		in_word_t  w;
		logic      typed;
		out_word_t want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	function automatic void expect_word(input out_word_t o);
		readout_q.insert(readout_q.size(), o);
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic signed [COORD_W-1:0] z, input logic [CAND_W-1:0] idx,
			input logic typed = 1'b0, input logic [CAND_W-1:0] e_idx = '0,
			input logic [DIST_W-1:0] e_dist = '0, input logic e_valid = 1'b0);
		dir_row_t row;
		row.w.op              = op;
		row.w.coord_x         = x;
		row.w.coord_y         = y;
		row.w.coord_z         = z;
		row.w.cand_index      = idx;
		row.typed             = typed;
		// typed rows are all one-entry or empty readouts: rank 0, last set
		row.want.nb_index     = e_idx;
		row.want.nb_dist_sq   = e_dist;
		row.want.rank         = '0;
		row.want.entry_valid  = e_valid;
		row.want.enough_found = 1'b0;
		row.want.last         = 1'b1;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Apply one accepted word to the predictor; a READ queues its words.
	function automatic void track_nearest(input in_word_t w);
		longint          dx, dy, dz;
		logic [DIST_W-1:0] d;
		int unsigned     k, pos, n, r;
		bit              take;
		out_word_t       o;
		case (w.op)
			OP_QUERY: begin
				qry_x   = w.coord_x;
				qry_y   = w.coord_y;
				qry_z   = w.coord_z;
				found_n = 0;
			end
			OP_OFFER: begin
				dx = w.coord_x;
				dx -= qry_x;
				dy = w.coord_y;
				dy -= qry_y;
				dz = w.coord_z;
				dz -= qry_z;
				d = DIST_W'(dx * dx + dy * dy + dz * dz);
				k = (k_limit < MAX_NB) ? k_limit : MAX_NB;
				if (k != 0) begin
					// a lowered limit trims the farthest entries first
					if (found_n > k)
						found_n = k;
					take = 1'b1;
					pos = 0;
					if (found_n < k) begin
						pos = found_n;
						found_n++;
					end else if (d < nb_dist[k-1]) begin
						pos = k - 1;
					end else begin
						take = 1'b0;
					end
					if (take) begin
						// strict compare keeps earlier arrivals ahead on ties
						while (pos > 0 && nb_dist[pos-1] > d) begin
							nb_dist[pos] = nb_dist[pos-1];
							nb_idx[pos]  = nb_idx[pos-1];
							pos--;
						end
						nb_dist[pos] = d;
						nb_idx[pos]  = w.cand_index;
					end
				end
			end
			OP_READ: begin
				n = (found_n > MAX_NB) ? MAX_NB : found_n;
				if (n > READOUT_MAX)
					n = READOUT_MAX;
				if (n == 0) begin
					o = '0;
					o.last = 1'b1;
					expect_word(o);
				end else begin
					for (r = 0; r < n; r++) begin
						o.nb_index     = nb_idx[r];
						o.nb_dist_sq   = nb_dist[r];
						o.rank         = r[RANK_W-1:0];
						o.entry_valid  = 1'b1;
						o.enough_found = (found_n >= ENOUGH_COUNT);
						o.last         = (r + 1 == n);
						expect_word(o);
					end
				end
			end
			OP_UNUSED: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_word(input out_word_t got);
		out_word_t want;
		if (readout_q.size() == 0) begin
			report_mismatch($sformatf("word with none expected: index %0h rank %0d",
				got.nb_index, got.rank));
		end else begin
			want = readout_q.pop_front();
			if (got.nb_index !== want.nb_index)
				report_mismatch($sformatf("nb_index got %0h want %0h",
					got.nb_index, want.nb_index));
			if (got.nb_dist_sq !== want.nb_dist_sq)
				report_mismatch($sformatf("nb_dist_sq got %0h want %0h",
					got.nb_dist_sq, want.nb_dist_sq));
			if (got.rank !== want.rank)
				report_mismatch($sformatf("rank got %0d want %0d", got.rank, want.rank));
			if (got.entry_valid !== want.entry_valid)
				report_mismatch($sformatf("entry_valid got %0b want %0b",
					got.entry_valid, want.entry_valid));
			if (got.enough_found !== want.enough_found)
				report_mismatch($sformatf("enough_found got %0b want %0b",
					got.enough_found, want.enough_found));
			if (got.last !== want.last)
				report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
		end
	endtask

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one word, with random idle cycles first; predict on acceptance.
	// valid is left high after acceptance so back-to-back words need no gap.
	task automatic send_word(input in_word_t w, input logic typed = 1'b0,
			input out_word_t want = '0);
		while ($urandom_range(99) < idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= w;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (w.op != OP_UNUSED)
			item_count++;
		if (typed)
			expect_word(want);
		else
			track_nearest(w);
	endtask

	// Stop sending, wait for every expected word, then let the back end settle
	// (query and offer words leave nothing to wait on).
	task automatic drain();
		req_if.valid <= 1'b0;
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_neighbor_limit(input logic [CFG_W-1:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		k_limit = v;
		cfg_we  <= 1'b0;
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			default: return COORD_W'($urandom());
		endcase
	endfunction

	// small offset from the query so ties and close calls are common
	function automatic logic signed [COORD_W-1:0] near_coord(
			input logic signed [COORD_W-1:0] q);
		int j;
		j = $urandom_range(6);
		return COORD_W'(q + j - 3);
	endfunction

	function automatic in_word_t random_word(input logic [OP_W-1:0] op);
		in_word_t w;
		w.op         = op;
		w.coord_x    = pick_coord();
		w.coord_y    = pick_coord();
		w.coord_z    = pick_coord();
		w.cand_index = CAND_W'($urandom());
		return w;
	endfunction

	// One search: optional new query, a run of candidates with the odd
	// stray read or unused op mixed in, then a readout.
	task automatic random_round(input bit fresh, input int offers, input bit near);
		in_word_t w;
		int       i, pick;
		if (fresh)
			send_word(random_word(OP_QUERY));
		for (i = 0; i < offers; i++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				send_word(random_word(OP_UNUSED));
			else if (pick < 10)
				send_word(random_word(OP_READ));
			w = random_word(OP_OFFER);
			if (near) begin
				w.coord_x = near_coord(qry_x);
				w.coord_y = near_coord(qry_y);
				w.coord_z = near_coord(qry_z);
			end
			send_word(w);
		end
		send_word(random_word(OP_READ));
	endtask

	// ------------------------------------------------------------------
	// Receiver side: random ready, plus one long stall on request
	// ------------------------------------------------------------------
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready)
				check_word(rsp_if.data);
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Watchdog: too long with no word moving on either side.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int i;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_data     <= '0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;

		qry_x   = '0;
		qry_y   = '0;
		qry_z   = '0;
		found_n = 0;
		k_limit = CFG_W'(LIMIT_RESET);
		for (i = 0; i < MAX_NB; i++) begin
			nb_dist[i] = '0;
			nb_idx[i]  = '0;
		end

		// Directed part, run at the reset limit of 16.
		// readout straight after reset: empty list word
		add_row(OP_READ, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0);
		// unused op with every bit set is dropped
		add_row(OP_UNUSED, -1, -1, -1, 16'hFFFF);
		add_row(OP_READ, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0);
		// origin query, farthest corner candidate
		add_row(OP_QUERY, 0, 0, 0, 0);
		add_row(OP_OFFER, COORD_MIN, COORD_MIN, COORD_MIN, 16'hFFFF);
		add_row(OP_READ, 0, 0, 0, 0, 1'b1, 16'hFFFF, DIST_MIN_ORIGIN, 1'b1);
		// full span on every axis: the largest distance there is
		add_row(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 0);
		add_row(OP_OFFER, COORD_MAX, COORD_MAX, COORD_MAX, 16'h0000);
		add_row(OP_READ, 0, 0, 0, 0, 1'b1, 16'h0000, DIST_FULL_SPAN, 1'b1);
		// zero distance, then three equal distances: arrival order must hold
		add_row(OP_OFFER, COORD_MIN, COORD_MIN, COORD_MIN, 16'h0001);
		add_row(OP_OFFER, COORD_MIN + 1, COORD_MIN, COORD_MIN, 16'h0002);
		add_row(OP_OFFER, COORD_MIN, COORD_MIN + 1, COORD_MIN, 16'h0003);
		add_row(OP_OFFER, COORD_MIN, COORD_MIN, COORD_MIN + 1, 16'h0004);
		add_row(OP_READ, 0, 0, 0, 0);
		// alternating bit patterns through the distance path
		add_row(OP_QUERY, 24'sh555555, 24'shAAAAAA, 24'sh000000, 0);
		add_row(OP_OFFER, 24'shAAAAAA, 24'sh555555, 24'shFFFFFF, 16'hAAAA);
		add_row(OP_OFFER, 24'sh555555, 24'shAAAAAA, 24'sh000001, 16'h5555);
		add_row(OP_READ, 0, 0, 0, 0);
		add_row(OP_UNUSED, 0, 0, 0, 0);
		// a new query empties the list
		add_row(OP_QUERY, 0, 0, 0, 0);
		add_row(OP_READ, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[j])
			send_word(dir_rows[j].w, dir_rows[j].typed, dir_rows[j].want);

		// k = 1: only the single nearest survives
		set_neighbor_limit(1);
		random_round(1'b1, 4, 1'b0);
		random_round(1'b1, 4, 1'b1);

		// k at list depth, overfilled so replacements happen; 32-word readouts
		set_neighbor_limit(CFG_W'(MAX_NB));
		random_round(1'b1, 34, 1'b0);
		// receiver stalls long while a readout and more words pile in behind it
		hold_req = 1'b1;
		send_word(random_word(OP_READ));
		random_round(1'b0, 12, 1'b1);

		// limit lowered mid-query: next offer trims the list to 5
		set_neighbor_limit(5);
		random_round(1'b0, 4, 1'b1);

		// above list depth: clamped to 32
		set_neighbor_limit(6'd63);
		random_round(1'b1, 34, 1'b1);

		// k = 0: every offer ignored, readouts stay empty
		set_neighbor_limit(0);
		random_round(1'b1, 5, 1'b0);

		// stretch with no idling on either side, right at the enough threshold
		idle_pct = 0;
		set_neighbor_limit(CFG_W'(ENOUGH_COUNT));
		repeat (3) random_round(1'b1, 6, 1'b1);
		idle_pct = IDLE_PCT;

		// random limits until the item budget is spent
		while (item_count < ITEM_TARGET) begin
			set_neighbor_limit(CFG_W'($urandom_range(1, MAX_NB)));
			random_round(1'b1, $urandom_range(2, 20), 1'($urandom_range(1)));
		end

		drain();
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
